FILE: sv/mie_pkg.sv
// Shared types and instruction encodings for the integer execute unit.
package mie_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned CODE_W   = 20;
    localparam int unsigned NREGS    = 32;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    typedef enum logic [1:0] {
        TRAP_NONE    = 2'd0,
        TRAP_SYSCALL = 2'd1,
        TRAP_BREAK   = 2'd2
    } t_trap;

    // Register file write port
    typedef struct packed {
        logic             en;
        logic [REG_W-1:0] addr;
        logic [XLEN-1:0]  data;
    } t_wr;

    // Everything one instruction produces
    typedef struct packed {
        logic              wr_en;
        logic [REG_W-1:0]  wr_reg;
        logic [XLEN-1:0]   wr_value;
        logic [XLEN-1:0]   hi_value;
        logic [XLEN-1:0]   lo_value;
        t_trap             trap_kind;
        logic [CODE_W-1:0] trap_code;
        logic              unsupported;
    } t_exec_res;

endpackage

FILE: sv/mie_regfile.sv
// General register file: synchronous two-read one-write memory with write forwarding.
module mie_regfile
    import mie_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [REG_W-1:0] i_rd_addr_a,
    input  logic [REG_W-1:0] i_rd_addr_b,
    input  logic [REG_W-1:0] i_op_addr_a,
    input  logic [REG_W-1:0] i_op_addr_b,
    input  t_wr              i_wr,
    output logic [XLEN-1:0]  o_op_a,
    output logic [XLEN-1:0]  o_op_b
);

    logic [XLEN-1:0]  mem [NREGS];
    logic [NREGS-1:0] r_written;
    logic [XLEN-1:0]  r_rdata_a;
    logic [XLEN-1:0]  r_rdata_b;
    logic             r_fwd_en;
    logic [REG_W-1:0] r_fwd_addr;
    logic [XLEN-1:0]  r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata_a <= mem[i_rd_addr_a];
        r_rdata_b <= mem[i_rd_addr_b];
    end

    // Entries never written read as zero; register 0 is never written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_fwd_en  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            r_fwd_en <= i_wr.en;
        end
    end

    // Hold the write of the same edge as the read: the memory returns old data for it.
    always_ff @(posedge i_clk) begin
        r_fwd_addr <= i_wr.addr;
        r_fwd_data <= i_wr.data;
    end

    always_comb begin
        if (r_fwd_en && r_fwd_addr == i_op_addr_a) begin
            o_op_a = r_fwd_data;
        end else if (r_written[i_op_addr_a]) begin
            o_op_a = r_rdata_a;
        end else begin
            o_op_a = '0;
        end
        if (r_fwd_en && r_fwd_addr == i_op_addr_b) begin
            o_op_b = r_fwd_data;
        end else if (r_written[i_op_addr_b]) begin
            o_op_b = r_rdata_b;
        end else begin
            o_op_b = '0;
        end
    end

endmodule

FILE: sv/mie_exec.sv
// Instruction decode, ALU, shifter and multiplier for one instruction.
module mie_exec
    import mie_pkg::*;
(
    input  logic [XLEN-1:0] i_instr,
    input  logic [XLEN-1:0] i_op_a,
    input  logic [XLEN-1:0] i_op_b,
    input  logic [XLEN-1:0] i_hi,
    input  logic [XLEN-1:0] i_lo,
    output t_exec_res       o_res
);

    logic [5:0]        op;
    logic [5:0]        fn;
    logic [REG_W-1:0]  rt;
    logic [REG_W-1:0]  rd;
    logic [REG_W-1:0]  sh;
    logic [REG_W-1:0]  vsh;
    logic [15:0]       imm;
    logic [XLEN-1:0]   zimm;
    logic [XLEN-1:0]   simm;
    logic              mul_signed;
    logic signed [XLEN:0]     mul_a;
    logic signed [XLEN:0]     mul_b;
    logic signed [2*XLEN+1:0] prod;
    logic              wr;
    logic [REG_W-1:0]  dst;
    logic [XLEN-1:0]   val;

    assign op   = i_instr[31:26];
    assign rt   = i_instr[20:16];
    assign rd   = i_instr[15:11];
    assign sh   = i_instr[10:6];
    assign fn   = i_instr[5:0];
    assign imm  = i_instr[15:0];
    assign vsh  = i_op_a[REG_W-1:0];
    assign zimm = {16'h0000, imm};
    assign simm = {{16{imm[15]}}, imm};

    assign mul_signed = (fn == FN_MULT);
    assign mul_a = $signed({mul_signed & i_op_a[XLEN-1], i_op_a});
    assign mul_b = $signed({mul_signed & i_op_b[XLEN-1], i_op_b});
    assign prod  = mul_a * mul_b;

    always_comb begin
        o_res          = '0;
        o_res.hi_value = i_hi;
        o_res.lo_value = i_lo;
        wr             = 1'b0;
        dst            = '0;
        val            = '0;
        if (i_instr != '0) begin
            if (op == OP_SPECIAL) begin
                wr  = 1'b1;
                dst = rd;
                unique case (fn)
                    FN_SLL:  val = i_op_b << sh;
                    FN_SRL:  val = i_op_b >> sh;
                    FN_SRA:  val = $unsigned($signed(i_op_b) >>> sh);
                    FN_SLLV: val = i_op_b << vsh;
                    FN_SRLV: val = i_op_b >> vsh;
                    FN_SRAV: val = $unsigned($signed(i_op_b) >>> vsh);
                    FN_MFHI: val = i_hi;
                    FN_MFLO: val = i_lo;
                    FN_MTHI: begin
                        wr             = 1'b0;
                        o_res.hi_value = i_op_a;
                    end
                    FN_MTLO: begin
                        wr             = 1'b0;
                        o_res.lo_value = i_op_a;
                    end
                    FN_MULT, FN_MULTU: begin
                        wr             = 1'b0;
                        o_res.hi_value = prod[2*XLEN-1:XLEN];
                        o_res.lo_value = prod[XLEN-1:0];
                    end
                    FN_ADD, FN_ADDU: val = i_op_a + i_op_b;
                    FN_SUB, FN_SUBU: val = i_op_a - i_op_b;
                    FN_AND:  val = i_op_a & i_op_b;
                    FN_OR:   val = i_op_a | i_op_b;
                    FN_XOR:  val = i_op_a ^ i_op_b;
                    FN_NOR:  val = ~(i_op_a | i_op_b);
                    FN_SLT:  val = {31'd0, $signed(i_op_a) < $signed(i_op_b)};
                    FN_SLTU: val = {31'd0, i_op_a < i_op_b};
                    FN_SYSCALL: begin
                        wr              = 1'b0;
                        o_res.trap_kind = TRAP_SYSCALL;
                        o_res.trap_code = i_instr[25:6];
                    end
                    FN_BREAK: begin
                        wr              = 1'b0;
                        o_res.trap_kind = TRAP_BREAK;
                        o_res.trap_code = i_instr[25:6];
                    end
                    default: begin
                        wr                = 1'b0;
                        o_res.unsupported = 1'b1;
                    end
                endcase
            end else begin
                wr  = 1'b1;
                dst = rt;
                unique case (op)
                    OP_LUI:             val = {imm, 16'h0000};
                    OP_ADDI, OP_ADDIU:  val = i_op_a + simm;
                    OP_SLTI:  val = {31'd0, $signed(i_op_a) < $signed(simm)};
                    OP_SLTIU: val = {31'd0, i_op_a < simm};
                    OP_ANDI:  val = i_op_a & zimm;
                    OP_ORI:   val = i_op_a | zimm;
                    OP_XORI:  val = i_op_a ^ zimm;
                    default: begin
                        wr                = 1'b0;
                        o_res.unsupported = 1'b1;
                    end
                endcase
            end
        end
        // Writes to register 0 are dropped
        if (wr && dst != '0) begin
            o_res.wr_en    = 1'b1;
            o_res.wr_reg   = dst;
            o_res.wr_value = val;
        end
    end

endmodule

FILE: sv/mips_integer_execute_unit.sv
// An input transfer loads the execute stage register; the result then registers into
// the output register, which drives o_valid.
// Throughput: one instruction per cycle unless i_stall holds the output; the register
// file memory reads both sources in the transfer cycle and takes the write-back, forwarded.
// The execute stage holds a 33x33 multiplier whose product registers into HI/LO.
// Reset: control cleared, HI/LO zero, every register reads zero until first written.
module mips_integer_execute_unit
    import mie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_instr,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_wr_en,
    output logic [4:0]  o_wr_reg,
    output logic [31:0] o_wr_value,
    output logic [31:0] o_hi_value,
    output logic [31:0] o_lo_value,
    output logic [1:0]  o_trap_kind,
    output logic [19:0] o_trap_code,
    output logic        o_unsupported
);

    logic             r_s1_valid;
    logic             n_s1_valid;
    logic [XLEN-1:0]  r_s1_instr;
    logic             r_out_valid;
    t_exec_res        r_out;
    logic [XLEN-1:0]  r_hi;
    logic [XLEN-1:0]  r_lo;
    logic             adv;
    logic             s1_load;
    logic [REG_W-1:0] rd_addr_a;
    logic [REG_W-1:0] rd_addr_b;
    logic [XLEN-1:0]  op_a;
    logic [XLEN-1:0]  op_b;
    t_wr              wr;
    t_exec_res        res;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !adv;
    assign s1_load = i_valid && !o_stall;

    // Re-read the held instruction's sources while it waits in the execute stage.
    assign rd_addr_a = s1_load ? i_instr[25:21] : r_s1_instr[25:21];
    assign rd_addr_b = s1_load ? i_instr[20:16] : r_s1_instr[20:16];

    assign wr.en   = adv && r_s1_valid && res.wr_en;
    assign wr.addr = res.wr_reg;
    assign wr.data = res.wr_value;

    mie_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_op_addr_a (r_s1_instr[25:21]),
        .i_op_addr_b (r_s1_instr[20:16]),
        .i_wr        (wr),
        .o_op_a      (op_a),
        .o_op_b      (op_b)
    );

    mie_exec u_exec (
        .i_instr (r_s1_instr),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .i_hi    (r_hi),
        .i_lo    (r_lo),
        .o_res   (res)
    );

    always_comb begin
        if (s1_load) begin
            n_s1_valid = 1'b1;
        end else if (adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hi        <= '0;
            r_lo        <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_hi <= res.hi_value;
                    r_lo <= res.lo_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_instr <= i_instr;
        end
        if (adv && r_s1_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_wr_en       = r_out.wr_en;
    assign o_wr_reg      = r_out.wr_reg;
    assign o_wr_value    = r_out.wr_value;
    assign o_hi_value    = r_out.hi_value;
    assign o_lo_value    = r_out.lo_value;
    assign o_trap_kind   = r_out.trap_kind;
    assign o_trap_code   = r_out.trap_code;
    assign o_unsupported = r_out.unsupported;

endmodule
